@@ design/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg - shared types and constants for the damper self-check sequencer
// Beat payloads, configuration register map, reset values and phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_THRESHOLD   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOSED_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_TIMEOUT     = 2'd2;

  // Register reset values
  localparam logic [15:0] OPEN_THRESHOLD_RST   = 16'd4500;
  localparam logic [15:0] CLOSED_THRESHOLD_RST = 16'd500;
  localparam logic [15:0] MOVE_TIMEOUT_RST     = 16'd30000;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;
  localparam logic [7:0]  FAULT_MAX = 8'hFF;

  // Sequencer phase codes as seen on the result beat
  localparam logic [2:0] PHASE_PROBE       = 3'd0;
  localparam logic [2:0] PHASE_WAIT_OPEN1  = 3'd1;
  localparam logic [2:0] PHASE_START_CLOSE = 3'd2;
  localparam logic [2:0] PHASE_WAIT_CLOSED = 3'd3;
  localparam logic [2:0] PHASE_PASSED      = 3'd4;
  localparam logic [2:0] PHASE_WAIT_OPEN2  = 3'd5;
  localparam logic [2:0] PHASE_FAILED      = 3'd6;

  typedef struct packed {
    logic [15:0] feedback;
    logic [7:0]  elapsed_ms;
  } dsc_in_t;

  typedef struct packed {
    logic       open_drive;
    logic       close_drive;
    logic [2:0] phase;
    logic       finished;
    logic [7:0] fault_count;
  } dsc_out_t;

  typedef struct packed {
    logic [15:0] open_threshold;
    logic [15:0] closed_threshold;
    logic [15:0] move_timeout_ms;
  } dsc_cfg_t;

endpackage

`default_nettype wire

@@ design/damper_self_check_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// damper_self_check_fsm_unit - damper self-check sequencer, top level
// Stages each check-step beat, runs one sequencer step and registers the
// result beat for the downstream side.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | in        | in_valid / in_stall    | in_data  (dsc_in_t)
//   out     | out       | out_valid / out_stall  | out_data (dsc_out_t)
//   cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// One beat per clock sustained while out_stall is low; each beat passes
// through the input stage register, then the result register.
// The sequencer state advances only when a staged beat moves into the result
// register, so state and results stay in step under any stall pattern.
// rst is synchronous: phase probe, timers and fault count zero, drives off,
// registers back to their defaults.
// out_stall holds the result register; the input stage then fills and
// in_stall rises until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module damper_self_check_fsm_unit
  import dsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire dsc_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output dsc_out_t                    out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  dsc_cfg_t cfg;
  dsc_out_t result;
  dsc_in_t  s1_data;
  logic     s1_valid;
  logic     out_free;
  logic     advance;

  // Result register can take a beat when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  dsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dsc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_data),
    .cfg    (cfg),
    .result (result)
  );

  // Input stage: take a beat whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_finished_terminal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |->
      (out_data.phase == PHASE_PASSED) || (out_data.phase == PHASE_FAILED))
    else $error("finished set outside a terminal phase");

  a_drives_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.open_drive && out_data.close_drive))
    else $error("open and close drives both active");

  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result beat appeared without a staged input beat");
`endif

endmodule

`default_nettype wire

@@ design/dsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dsc_cfg_regs - configuration registers
// Holds the thresholds and the move timeout; writes beyond the map are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_cfg_regs
  import dsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output dsc_cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_threshold   <= OPEN_THRESHOLD_RST;
      cfg.closed_threshold <= CLOSED_THRESHOLD_RST;
      cfg.move_timeout_ms  <= MOVE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPEN_THRESHOLD:   cfg.open_threshold   <= cfg_data;
        CFG_CLOSED_THRESHOLD: cfg.closed_threshold <= cfg_data;
        CFG_MOVE_TIMEOUT:     cfg.move_timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/dsc_seq.sv @@
// ----------------------------------------------------------------------------
// dsc_seq - self-check sequencer state and step logic
// Computes one step from the staged beat and commits the state when fired.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_seq
  import dsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire dsc_in_t  item,
  input  wire dsc_cfg_t cfg,
  output dsc_out_t      result
);

  typedef enum logic [2:0] {
    PH_PROBE       = PHASE_PROBE,
    PH_WAIT_OPEN1  = PHASE_WAIT_OPEN1,
    PH_START_CLOSE = PHASE_START_CLOSE,
    PH_WAIT_CLOSED = PHASE_WAIT_CLOSED,
    PH_PASSED      = PHASE_PASSED,
    PH_WAIT_OPEN2  = PHASE_WAIT_OPEN2,
    PH_FAILED      = PHASE_FAILED
  } phase_t;

  phase_t      phase, phase_next;
  logic        opened_once, opened_once_next;
  logic [15:0] open_timer, open_timer_next;
  logic [15:0] close_timer, close_timer_next;
  logic [7:0]  fault_counter, fault_counter_next;
  logic        done_flag, done_flag_next;
  logic        open_out, open_out_next;
  logic        close_out, close_out_next;

  logic [16:0] open_sum, close_sum;
  logic [15:0] open_acc, close_acc;
  logic [7:0]  fault_inc;
  logic        is_open, is_closed;
  logic        open_expired, close_expired;

  always_comb begin
    open_sum  = {1'b0, open_timer} + {9'b0, item.elapsed_ms};
    close_sum = {1'b0, close_timer} + {9'b0, item.elapsed_ms};
    open_acc  = open_sum[16] ? TIMER_MAX : open_sum[15:0];
    close_acc = close_sum[16] ? TIMER_MAX : close_sum[15:0];
    fault_inc = (fault_counter == FAULT_MAX) ? fault_counter : fault_counter + 8'd1;

    is_open       = item.feedback >= cfg.open_threshold;
    is_closed     = item.feedback <= cfg.closed_threshold;
    open_expired  = open_acc >= cfg.move_timeout_ms;
    close_expired = close_acc >= cfg.move_timeout_ms;

    phase_next         = phase;
    opened_once_next   = opened_once;
    open_timer_next    = open_acc;
    close_timer_next   = close_acc;
    fault_counter_next = fault_counter;
    done_flag_next     = done_flag;
    open_out_next      = open_out;
    close_out_next     = close_out;

    unique case (phase)
      PH_PROBE: begin
        if (is_closed) begin
          open_out_next    = 1'b1;
          close_out_next   = 1'b0;
          open_timer_next  = '0;
          opened_once_next = 1'b1;
          phase_next       = PH_WAIT_OPEN1;
        end else begin
          phase_next = PH_START_CLOSE;
        end
      end
      PH_WAIT_OPEN1: begin
        if (is_open) begin
          phase_next = PH_PROBE;
        end else if (open_expired) begin
          open_out_next      = 1'b0;
          close_out_next     = 1'b1;
          close_timer_next   = '0;
          fault_counter_next = fault_inc;
          phase_next         = PH_FAILED;
        end
      end
      PH_START_CLOSE: begin
        open_out_next    = 1'b0;
        close_out_next   = 1'b1;
        close_timer_next = '0;
        phase_next       = PH_WAIT_CLOSED;
      end
      PH_WAIT_CLOSED: begin
        if (is_closed) begin
          if (!opened_once) begin
            open_out_next   = 1'b1;
            close_out_next  = 1'b0;
            open_timer_next = '0;
            phase_next      = PH_WAIT_OPEN2;
          end else begin
            open_out_next      = 1'b0;
            close_out_next     = 1'b1;
            close_timer_next   = '0;
            fault_counter_next = '0;
            phase_next         = PH_PASSED;
          end
        end else if (close_expired) begin
          open_out_next      = 1'b0;
          close_out_next     = 1'b1;
          close_timer_next   = '0;
          fault_counter_next = fault_inc;
          phase_next         = PH_FAILED;
        end
      end
      PH_WAIT_OPEN2: begin
        if (is_open) begin
          open_out_next    = 1'b0;
          close_out_next   = 1'b1;
          close_timer_next = '0;
          opened_once_next = 1'b1;
          phase_next       = PH_WAIT_CLOSED;
        end else if (open_expired) begin
          open_out_next      = 1'b0;
          close_out_next     = 1'b1;
          close_timer_next   = '0;
          fault_counter_next = fault_inc;
          phase_next         = PH_FAILED;
        end
      end
      PH_PASSED, PH_FAILED: begin
        done_flag_next = 1'b1;
      end
      default: ;  // unreachable code: hold
    endcase

    result.open_drive  = open_out_next;
    result.close_drive = close_out_next;
    result.phase       = phase_next;
    result.finished    = done_flag_next;
    result.fault_count = fault_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PROBE;
      opened_once   <= 1'b0;
      open_timer    <= '0;
      close_timer   <= '0;
      fault_counter <= '0;
      done_flag     <= 1'b0;
      open_out      <= 1'b0;
      close_out     <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      opened_once   <= opened_once_next;
      open_timer    <= open_timer_next;
      close_timer   <= close_timer_next;
      fault_counter <= fault_counter_next;
      done_flag     <= done_flag_next;
      open_out      <= open_out_next;
      close_out     <= close_out_next;
    end
  end

endmodule

`default_nettype wire
